@@ rtl/scs_pkg.sv @@
// scs_pkg: types and constants shared by the comment stripper
// holds scan modes, result kinds, character codes and the result record
// no dependencies
`default_nettype none

package scs_pkg;

    // result kinds
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_END       = 2'd1;
    localparam logic [1:0] KIND_OPEN_BLK  = 2'd2;
    localparam logic [1:0] KIND_STRAY_END = 2'd3;

    // character codes
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;

    localparam int LINE_W  = 24;
    localparam int QDEPTH  = 4;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // scan modes, one-hot
    typedef enum logic [6:0] {
        M_NORMAL = 7'b0000001,
        M_QUOTE  = 7'b0000010,
        M_HSLASH = 7'b0000100,
        M_HSTAR  = 7'b0001000,
        M_LINEC  = 7'b0010000,
        M_BLOCK  = 7'b0100000,
        M_BSTAR  = 7'b1000000
    } t_mode;

    // one result beat
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data;
        logic [LINE_W-1:0] line;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/source_comment_stripper_unit.sv @@
// source_comment_stripper_unit: strips comments from a byte stream
// one scan step per input beat, results queued in a four-entry shift queue
// depends on scs_pkg
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+--------------------------------------------
//  input   | i_valid | o_stall | i_kind, i_in_byte
//  output  | o_valid | i_stall | o_out_kind, o_out_byte, o_line_number, o_last
//
// an input beat is scanned in the cycle it is accepted; its results are
// registered into the queue and leave in order, one beat per cycle while i_stall is low.
// each input beat gives zero, one or two results; the output port moves one per cycle
// while i_stall is low, so bytes that release a held slash or star take two beats.
// the input stalls while more than two results wait in the queue.
// synchronous active-low reset: normal text mode, line one, empty queue.
`default_nettype none

module source_comment_stripper_unit
    import scs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_kind,
    input  wire logic [7:0]        i_in_byte,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [1:0]             o_out_kind,
    output logic [7:0]             o_out_byte,
    output logic [LINE_W-1:0]      o_line_number,
    output logic                   o_last
);

    t_mode              r_mode, n_mode;
    logic               r_qdbl, n_qdbl;
    logic [LINE_W-1:0]  r_line, n_line;
    logic               r_nlp, n_nlp;
    t_result            r_q [QDEPTH];
    t_result            n_q [QDEPTH];
    logic [QCNT_W-1:0]  r_count, n_count;

    logic               accept;
    logic               pop;
    logic [QCNT_W-1:0]  base;
    logic [LINE_W-1:0]  line_eff;
    logic [1:0]         nres;
    t_result            res0, res1;

    // plain-text handling of the current byte
    logic               p_emit;
    t_mode              p_mode;
    logic               p_quote;
    logic               b_nl;
    logic               q_hit;

    assign accept  = i_valid && !o_stall;
    assign pop     = (r_count != '0) && !i_stall;
    assign o_stall = r_count > QCNT_W'(QDEPTH - 2);

    assign o_valid       = r_count != '0;
    assign o_out_kind    = r_q[0].kind;
    assign o_out_byte    = r_q[0].data;
    assign o_line_number = r_q[0].line;
    assign o_last        = r_q[0].last;

    // pending newline advances the counter at the start of the step
    assign line_eff = (r_nlp && (r_line != '1)) ? r_line + LINE_W'(1) : r_line;
    assign b_nl     = i_in_byte == CH_NEWLINE;
    assign q_hit    = i_in_byte == (r_qdbl ? CH_DQUOTE : CH_SQUOTE);

    // plain text: quotes open a literal, slash and star are held
    always_comb begin
        p_quote = (i_in_byte == CH_SQUOTE) || (i_in_byte == CH_DQUOTE);
        p_emit  = 1'b1;
        p_mode  = M_NORMAL;
        if (p_quote) begin
            p_mode = M_QUOTE;
        end else if (i_in_byte == CH_SLASH) begin
            p_emit = 1'b0;
            p_mode = M_HSLASH;
        end else if (i_in_byte == CH_STAR) begin
            p_emit = 1'b0;
            p_mode = M_HSTAR;
        end
    end

    // scan step
    always_comb begin
        n_mode = r_mode;
        n_qdbl = r_qdbl;
        n_line = line_eff;
        n_nlp  = 1'b0;
        nres   = 2'd0;
        res0   = '{kind: KIND_CHAR, data: 8'd0, line: line_eff, last: 1'b0};
        res1   = '{kind: KIND_CHAR, data: 8'd0, line: line_eff, last: 1'b0};
        if (i_kind) begin
            n_mode = M_NORMAL;
            case (r_mode)
                M_HSLASH: begin
                    nres      = 2'd2;
                    res0.data = CH_SLASH;
                    res1.kind = KIND_END;
                end
                M_HSTAR: begin
                    nres      = 2'd2;
                    res0.data = CH_STAR;
                    res1.kind = KIND_END;
                end
                M_BLOCK, M_BSTAR: begin
                    nres      = 2'd1;
                    res0.kind = KIND_OPEN_BLK;
                end
                default: begin
                    nres      = 2'd1;
                    res0.kind = KIND_END;
                end
            endcase
        end else begin
            case (r_mode)
                M_QUOTE: begin
                    nres      = 2'd1;
                    res0.data = i_in_byte;
                    n_nlp     = b_nl;
                    if (q_hit || b_nl) begin
                        n_mode = M_NORMAL;
                    end
                end
                M_HSLASH, M_HSTAR: begin
                    if (r_mode == M_HSLASH && i_in_byte == CH_SLASH) begin
                        n_mode = M_LINEC;
                    end else if (r_mode == M_HSLASH && i_in_byte == CH_STAR) begin
                        n_mode = M_BLOCK;
                    end else if (r_mode == M_HSTAR && i_in_byte == CH_SLASH) begin
                        nres      = 2'd1;
                        res0.kind = KIND_STRAY_END;
                        n_mode    = M_NORMAL;
                    end else begin
                        // held byte goes out first, then the new byte is handled as plain text
                        res0.data = (r_mode == M_HSLASH) ? CH_SLASH : CH_STAR;
                        res1.data = i_in_byte;
                        nres      = p_emit ? 2'd2 : 2'd1;
                        n_nlp     = p_emit && b_nl;
                        n_mode    = p_mode;
                        if (p_quote) begin
                            n_qdbl = i_in_byte == CH_DQUOTE;
                        end
                    end
                end
                M_LINEC: begin
                    if (b_nl) begin
                        nres      = 2'd1;
                        res0.data = CH_NEWLINE;
                        n_nlp     = 1'b1;
                        n_mode    = M_NORMAL;
                    end
                end
                M_BLOCK, M_BSTAR: begin
                    if (r_mode == M_BSTAR && i_in_byte == CH_SLASH) begin
                        nres      = 2'd1;
                        res0.data = CH_SPACE;
                        n_mode    = M_NORMAL;
                    end else begin
                        if (b_nl && (line_eff != '1)) begin
                            n_line = line_eff + LINE_W'(1);
                        end
                        n_mode = (i_in_byte == CH_STAR) ? M_BSTAR : M_BLOCK;
                    end
                end
                default: begin
                    res0.data = i_in_byte;
                    nres      = p_emit ? 2'd1 : 2'd0;
                    n_nlp     = p_emit && b_nl;
                    n_mode    = p_mode;
                    if (p_quote) begin
                        n_qdbl = i_in_byte == CH_DQUOTE;
                    end
                end
            endcase
        end
        // mark the final result of this beat
        if (nres == 2'd1) begin
            res0.last = 1'b1;
        end
        if (nres == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    // result queue: shift on pop, append behind the remaining entries
    always_comb begin
        base = r_count - QCNT_W'(pop);
        for (int i = 0; i < QDEPTH; i++) begin
            n_q[i] = (pop && i < QDEPTH - 1) ? r_q[(i + 1) % QDEPTH] : r_q[i];
            if (accept && nres != 2'd0 && base == QCNT_W'(i)) begin
                n_q[i] = res0;
            end
            if (accept && nres == 2'd2 && base + QCNT_W'(1) == QCNT_W'(i)) begin
                n_q[i] = res1;
            end
        end
        n_count = base + (accept ? QCNT_W'(nres) : QCNT_W'(0));
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_qdbl  <= 1'b0;
            r_line  <= LINE_W'(1);
            r_nlp   <= 1'b0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_mode <= n_mode;
                r_qdbl <= n_qdbl;
                r_line <= n_line;
                r_nlp  <= n_nlp;
            end
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind) |=> o_valid)
        else $error("end of input produced no result");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_line_number != '0)
        else $error("line number zero on output");

    a_end_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind) |=> (r_mode == M_NORMAL && !r_nlp))
        else $error("end of input left scanner out of normal text");
`endif

endmodule

`default_nettype wire
